>>> rtl/pose_frame_receiver_macros.svh
// assertion macros for the pose frame receiver
// used by pose_frame_receiver.sv, no other dependencies
`ifndef POSE_FRAME_RECEIVER_MACROS_SVH
`define POSE_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfr assertion failed");

// next-cycle implication, disabled during reset
`define PFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfr assertion failed");

`endif

>>> rtl/pfr_pkg.sv
// shared constants, types and state codes of the pose frame receiver
// no dependencies
package pfr_pkg;

    localparam int PAYLOAD_BYTES = 32;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int N_OUT         = 5;
    localparam int OUT_BYTES     = 4 * N_OUT;
    localparam int WADDR_W       = $clog2(N_OUT);

    localparam logic [7:0] BYTE_CR = 8'h0d;
    localparam logic [7:0] BYTE_LF = 8'h0a;
    localparam logic [7:0] BYTE_O  = 8'h4f;

    localparam logic [IDX_W-1:0]   LAST_IDX     = IDX_W'(PAYLOAD_BYTES - 1);
    localparam logic [IDX_W:0]     OUT_BYTES_W  = (IDX_W + 1)'(OUT_BYTES);
    localparam logic [WADDR_W-1:0] LAST_WORD    = WADDR_W'(N_OUT - 1);

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_HDR_LF  = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_TRL_LF  = 5'b01000,
        PH_TRL_CR  = 5'b10000
    } phase_t;

    // parser to storage: word write and frame completion
    typedef struct packed {
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [31:0]        wr_data;
        logic               frame_ok;
    } pfr_wr_t;

endpackage

>>> rtl/pfr_parser.sv
// frame parser: header/trailer state machine and little-endian word assembly
// depends on pfr_pkg
module pfr_parser
    import pfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output pfr_wr_t    wr
);

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [23:0]      asm_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        wr          = '0;
        wr.wr_addr  = idx_reg[IDX_W-1:2] < (IDX_W-2)'(N_OUT) ?
                      WADDR_W'(idx_reg[IDX_W-1:2]) : '0;
        wr.wr_data  = {rx_byte, asm_reg};
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == BYTE_CR || rx_byte == BYTE_O)
                        phase_next = PH_HDR_LF;
                end
                PH_HDR_LF:
                begin
                    if (rx_byte == BYTE_LF)
                    begin
                        idx_next   = '0;
                        phase_next = PH_PAYLOAD;
                    end
                    else if (rx_byte != BYTE_CR)
                        phase_next = PH_HUNT;
                end
                PH_PAYLOAD:
                begin
                    // only the emitted words are kept
                    wr.wr_en = (idx_reg[1:0] == 2'd3) && ({1'b0, idx_reg} < OUT_BYTES_W);
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next   = '0;
                        phase_next = PH_TRL_LF;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                PH_TRL_LF:
                begin
                    phase_next = (rx_byte == BYTE_LF) ? PH_TRL_CR : PH_HUNT;
                end
                PH_TRL_CR:
                begin
                    wr.frame_ok = (rx_byte == BYTE_CR);
                    phase_next  = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    // low three bytes of the word being assembled
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_PAYLOAD)
            asm_reg <= {rx_byte, asm_reg[23:8]};
    end

endmodule

>>> rtl/pose_frame_receiver.sv
// pose frame receiver: one byte per transaction, one five-word result per good frame
// result: after the trailer CR is accepted, the five words are read out and captured, then out_valid rises
// throughput: one byte per cycle; input stalls only while a finished result
// still holds the output register when the next frame completes
// readout: five reads of the word RAM, one per cycle
// reset: asynchronous active low, parser hunts for a header, word RAM is not cleared
`include "pose_frame_receiver_macros.svh"

module pose_frame_receiver
    import pfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] angle_x_bits,
    output logic [31:0] angle_y_bits,
    output logic [31:0] angle_z_bits,
    output logic [31:0] pos_x_bits,
    output logic [31:0] pos_y_bits
);

    pfr_wr_t            wr;
    logic               accept;
    logic               pend_reg, pend_next;
    logic               rd_active_reg;
    logic [WADDR_W-1:0] rd_cnt_reg;
    logic               cap_vld_reg;
    logic [WADDR_W-1:0] cap_idx_reg;
    logic [31:0]        rd_data_reg;
    logic               out_valid_reg;
    logic [31:0]        out_word_reg [N_OUT];
    logic               out_free;
    logic               start;
    logic [31:0]        word_mem [N_OUT];

    assign accept = in_valid && !in_stall;
    assign in_stall = pend_reg;

    pfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .wr      (wr)
    );

    assign out_free  = (!out_valid_reg || !out_stall) && !rd_active_reg && !cap_vld_reg;
    assign start     = (wr.frame_ok || pend_reg) && out_free;
    assign pend_next = (wr.frame_ok || pend_reg) && !out_free;

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
            word_mem[wr.wr_addr] <= wr.wr_data;
        rd_data_reg <= word_mem[rd_cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            rd_active_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            cap_vld_reg   <= 1'b0;
            cap_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg    <= pend_next;
            cap_vld_reg <= rd_active_reg;
            cap_idx_reg <= rd_cnt_reg;
            if (start)
            begin
                rd_active_reg <= 1'b1;
                rd_cnt_reg    <= '0;
            end
            else if (rd_active_reg)
            begin
                if (rd_cnt_reg == LAST_WORD)
                    rd_active_reg <= 1'b0;
                else
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            if (cap_vld_reg && cap_idx_reg == LAST_WORD)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_vld_reg)
            out_word_reg[cap_idx_reg] <= rd_data_reg;
    end

    assign out_valid    = out_valid_reg;
    assign angle_x_bits = out_word_reg[0];
    assign angle_y_bits = out_word_reg[1];
    assign angle_z_bits = out_word_reg[2];
    assign pos_x_bits   = out_word_reg[3];
    assign pos_y_bits   = out_word_reg[4];

    // readout never overwrites a result still waiting at the output
    `PFR_ASSERT_NOW(a_readout_out_empty, clk, rst_n, rd_active_reg || cap_vld_reg, !out_valid_reg)
    // a new frame never writes the word the readout is fetching
    `PFR_ASSERT_NOW(a_no_rw_clash, clk, rst_n, wr.wr_en && rd_active_reg, wr.wr_addr != rd_cnt_reg)
    // a pending frame blocks input, so no second frame can complete behind it
    `PFR_ASSERT_NOW(a_no_double_pend, clk, rst_n, pend_reg, !wr.frame_ok)
    // the last capture always raises the result
    `PFR_ASSERT_NEXT(a_capture_done, clk, rst_n, cap_vld_reg && cap_idx_reg == LAST_WORD,
        out_valid_reg)

endmodule

>>> sim/pose_frame_checker.sv
`timescale 1ns / 1ps
// checker for the pose frame receiver: tracks the byte stream, predicts pose results
// and compares every accepted result with the oldest prediction; needs pfr_pkg
module pose_frame_checker
    import pfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] angle_x_bits,
    input  logic [31:0] angle_y_bits,
    input  logic [31:0] angle_z_bits,
    input  logic [31:0] pos_x_bits,
    input  logic [31:0] pos_y_bits,
    input  logic        drain_done,
    output int          error_count,
    output int          pending,
    output int          frames_expected
);

    typedef struct packed {
        logic [31:0] angle_x;
        logic [31:0] angle_y;
        logic [31:0] angle_z;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
    } pose_t;

    pose_t       pose_q[$];
    phase_t      parse_phase;
    int unsigned payload_idx;
    logic [7:0]  payload_mem [PAYLOAD_BYTES];
    logic        leftover_reported;

    // little-endian word w of the stored payload
    function automatic logic [31:0] payload_word(input int w);
        return {payload_mem[4*w+3], payload_mem[4*w+2], payload_mem[4*w+1], payload_mem[4*w]};
    endfunction

    function automatic int field_differs(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %08h, got %08h", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic track_byte(input logic [7:0] b);
        pose_t p;
        case (parse_phase)
            PH_HUNT:
                parse_phase = (b == BYTE_CR || b == BYTE_O) ? PH_HDR_LF : PH_HUNT;
            PH_HDR_LF:
                if (b == BYTE_LF)
                begin
                    payload_idx = 0;
                    parse_phase = PH_PAYLOAD;
                end
                else if (b != BYTE_CR)
                begin
                    parse_phase = PH_HUNT;
                end
            PH_PAYLOAD:
            begin
                payload_mem[payload_idx] = b;
                payload_idx++;
                if (payload_idx >= PAYLOAD_BYTES)
                begin
                    payload_idx = 0;
                    parse_phase = PH_TRL_LF;
                end
            end
            PH_TRL_LF:
                parse_phase = (b == BYTE_LF) ? PH_TRL_CR : PH_HUNT;
            PH_TRL_CR:
            begin
                if (b == BYTE_CR)
                begin
                    p.angle_x = payload_word(0);
                    p.angle_y = payload_word(1);
                    p.angle_z = payload_word(2);
                    p.pos_x   = payload_word(3);
                    p.pos_y   = payload_word(4);
                    pose_q.push_back(p);
                    frames_expected++;
                end
                parse_phase = PH_HUNT;
            end
            default:
                parse_phase = PH_HUNT;
        endcase
    endtask

    task automatic check_result();
        pose_t p;
        if (pose_q.size() == 0)
        begin
            $error("result with no frame pending: angle_x_bits %08h", angle_x_bits);
            error_count++;
        end
        else
        begin
            p = pose_q.pop_front();
            error_count += field_differs("angle_x_bits", p.angle_x, angle_x_bits);
            error_count += field_differs("angle_y_bits", p.angle_y, angle_y_bits);
            error_count += field_differs("angle_z_bits", p.angle_z, angle_z_bits);
            error_count += field_differs("pos_x_bits", p.pos_x, pos_x_bits);
            error_count += field_differs("pos_y_bits", p.pos_y, pos_y_bits);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase       = PH_HUNT;
            payload_idx       = 0;
            pose_q.delete();
            error_count       = 0;
            frames_expected   = 0;
            leftover_reported = 1'b0;
        end
        else
        begin
            // results first: a byte taken at this edge cannot produce one at the same edge
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                track_byte(rx_byte);
            if (drain_done && !leftover_reported)
            begin
                leftover_reported = 1'b1;
                if (pose_q.size() != 0)
                begin
                    $error("%0d expected results never arrived", pose_q.size());
                    error_count += pose_q.size();
                end
            end
        end
        pending = pose_q.size();
    end

endmodule

>>> sim/tb_pose_frame_receiver.sv
`timescale 1ns / 1ps
// top of the pose frame receiver testbench: clock, reset, byte stimulus and receiver stalls
// depends on pfr_pkg, pose_frame_receiver and pose_frame_checker
module tb_pose_frame_receiver;
    import pfr_pkg::*;

    localparam logic [7:0] ASCII_K     = 8'h4b;
    localparam int         ITEM_TARGET = 1300;
    localparam int         POSE_TARGET = 20;
    localparam int         HOLD_CYCLES = 400;
    localparam int         DRAIN_WAIT  = 16;
    localparam int         CYCLE_LIMIT = 200000;

    typedef logic [7:0] byte_list_t[$];

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] angle_x_bits;
    logic [31:0] angle_y_bits;
    logic [31:0] angle_z_bits;
    logic [31:0] pos_x_bits;
    logic [31:0] pos_y_bits;
    logic        drain_done;

    int          error_count;
    int          pending;
    int          frames_expected;
    int unsigned cycle_count = 0;
    int          bytes_sent;
    logic        steady;
    logic        hold_req;

    pose_frame_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .angle_x_bits (angle_x_bits),
        .angle_y_bits (angle_y_bits),
        .angle_z_bits (angle_z_bits),
        .pos_x_bits   (pos_x_bits),
        .pos_y_bits   (pos_y_bits)
    );

    pose_frame_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .angle_x_bits    (angle_x_bits),
        .angle_y_bits    (angle_y_bits),
        .angle_z_bits    (angle_z_bits),
        .pos_x_bits      (pos_x_bits),
        .pos_y_bits      (pos_y_bits),
        .drain_done      (drain_done),
        .error_count     (error_count),
        .pending         (pending),
        .frames_expected (frames_expected)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver side: random stalls, plus one long hold-off so the block backs up
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                out_stall <= !steady && ($urandom_range(99) < 26);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        logic took;
        while (!steady && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        // nothing changes between the falling edge and the next rising edge
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end while (!took);
        bytes_sent++;
    endtask

    task automatic send_list(input byte_list_t bl);
        foreach (bl[i])
            send_byte(bl[i]);
    endtask

    // fill below zero means random payload bytes
    function automatic byte_list_t make_frame(input int fill, input int extra_cr,
                                              input logic o_header);
        byte_list_t fr;
        fr.push_back(o_header ? BYTE_O : BYTE_CR);
        repeat (extra_cr) fr.push_back(BYTE_CR);
        fr.push_back(BYTE_LF);
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            fr.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        fr.push_back(BYTE_LF);
        fr.push_back(BYTE_CR);
        return fr;
    endfunction

    function automatic byte_list_t random_frame();
        return make_frame(-1, $urandom_range(2), 1'($urandom_range(1)));
    endfunction

    initial
    begin
        byte_list_t fr;
        int         kind;
        int         cut;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = 8'h00;
        drain_done  = 1'b0;
        bytes_sent  = 0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // "OK" reply, a stray byte after a header, then extremes of the byte
        fr = {BYTE_O, ASCII_K, BYTE_CR, 8'hff, 8'h00, 8'hff};
        send_list(fr);
        // good frame with 'O' header, repeated CR, all-ones payload
        send_list(make_frame(8'hff, 2, 1'b1));
        // bad trailer CR
        fr = make_frame(8'h5a, 0, 1'b0);
        fr[fr.size()-1] = 8'h00;
        send_list(fr);
        // bad trailer LF
        fr = make_frame(8'ha5, 0, 1'b0);
        fr[fr.size()-2] = BYTE_CR;
        send_list(fr);
        // good frame with all-zero payload
        send_list(make_frame(8'h00, 0, 1'b0));
        send_list(make_frame(-1, 1, 1'b0));

        while (bytes_sent < ITEM_TARGET || frames_expected < POSE_TARGET)
        begin
            steady = (bytes_sent >= 800 && bytes_sent < 1000);
            if (bytes_sent >= 400 && bytes_sent < 440)
            begin
                // long receiver hold-off while good frames keep coming
                hold_req = 1'b1;
                repeat (5) send_list(random_frame());
            end
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                send_list(random_frame());
            end
            else if (kind < 85)
            begin
                fr  = random_frame();
                cut = $urandom_range(fr.size() - 1);
                if ($urandom_range(1))
                    fr[cut] = 8'($urandom);
                else
                    while (fr.size() > cut) void'(fr.pop_back());
                send_list(fr);
            end
            else
            begin
                fr.delete();
                repeat ($urandom_range(1, 8))
                begin
                    case ($urandom_range(4))
                        0: fr.push_back(BYTE_CR);
                        1: fr.push_back(BYTE_LF);
                        2: fr.push_back(BYTE_O);
                        3: fr.push_back(ASCII_K);
                        default: fr.push_back(8'($urandom));
                    endcase
                end
                send_list(fr);
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> pose_frame_receiver.f
+incdir+rtl
rtl/pfr_pkg.sv
rtl/pfr_parser.sv
rtl/pose_frame_receiver.sv
sim/pose_frame_checker.sv
sim/tb_pose_frame_receiver.sv
